FILE: rtl/core/grrg_pkg.sv
// Shared types and constants for the grid rectangle room grower.
// No dependencies.
package grrg_pkg;

  localparam int COORD_IN_W = 6;
  localparam int SIZE_W     = 7;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_BUILD = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ISSUE = 5'b00010,
    S_EVAL  = 5'b00100,
    S_MARK  = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  typedef enum logic [4:0] {
    PH_ORIGIN = 5'b00001,
    PH_SQ_COL = 5'b00010,
    PH_SQ_ROW = 5'b00100,
    PH_WIDE   = 5'b01000,
    PH_TALL   = 5'b10000
  } phase_t;

  typedef struct packed {
    logic rd;
    logic wr;
    logic wdata;
  } map_cmd_t;

endpackage

FILE: rtl/core/grid_rectangle_room_grower_top.sv
// Grid rectangle room grower: free-cell map plus room-growing sequencer.
// Depends on grrg_pkg and grrg_map.
//
// Input channel (in_valid/in_ready): action 0 writes cell_free into one cell
// of the map and gives no result; action 1 builds a room at (cell_x, cell_y).
// Output channel (out_valid/out_ready): one beat per build with room_width,
// room_height and room_ok (all zero when the origin is blocked or off-grid).
// A build checks cells one at a time (one map read issued, then evaluated):
// the origin, both edges of every grown square ring (corner checked twice),
// side cells for each column added by the widening pass and for each row
// added by the tall pass, and in each pass the cells probed up to the first
// blocked one. Marking then writes each cell of the room in turn, and the
// output register is loaded last. A blocked origin needs one check plus that
// load. One item is in work at a time and in_ready stays low meanwhile.
// After reset the map is cleared one cell per cycle, with in_ready low; all
// cells start blocked.
// The result sits in an output register, so loads and new builds are taken
// while it waits; a build that finishes while the register is still full
// holds until the receiver takes the older beat.
module grid_rectangle_room_grower_top
  import grrg_pkg::*;
#(
  parameter int GRID_WIDTH  = 64,
  parameter int GRID_HEIGHT = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  action,
  input  logic [COORD_IN_W-1:0] cell_x,
  input  logic [COORD_IN_W-1:0] cell_y,
  input  logic                  cell_free,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SIZE_W-1:0]     room_width,
  output logic [SIZE_W-1:0]     room_height,
  output logic                  room_ok
);

  localparam int MAXD = (GRID_WIDTH > GRID_HEIGHT) ? GRID_WIDTH : GRID_HEIGHT;
  localparam int CB   = $clog2(MAXD + 1);
  localparam int PW   = CB + 1;
  localparam int IW   = (PW > COORD_IN_W) ? PW : COORD_IN_W;

  state_t        state;
  phase_t        phase;
  logic [CB-1:0] ox, oy, side, wide, tall, k, mx, my, rw, rh;
  logic          rok;
  logic [CB-1:0] side_m1;

  map_cmd_t      cmd;
  logic [PW-1:0] cx, cy, mx_addr, my_addr;
  logic          map_busy;
  logic          open_bit;
  logic          in_fire;
  logic          in_grid;

  assign in_ready = (state == S_IDLE) && !map_busy;
  assign in_fire  = in_valid && in_ready;
  assign in_grid  = (IW'(cell_x) < IW'(GRID_WIDTH)) && (IW'(cell_y) < IW'(GRID_HEIGHT));
  assign side_m1  = side - 1'b1;

  always_comb begin
    case (phase)
      PH_ORIGIN: begin cx = PW'(ox);             cy = PW'(oy);             end
      PH_SQ_COL: begin cx = PW'(ox) + PW'(side); cy = PW'(oy) + PW'(k);    end
      PH_SQ_ROW: begin cx = PW'(ox) + PW'(k);    cy = PW'(oy) + PW'(side); end
      PH_WIDE:   begin cx = PW'(ox) + PW'(wide); cy = PW'(oy) + PW'(k);    end
      PH_TALL:   begin cx = PW'(ox) + PW'(k);    cy = PW'(oy) + PW'(tall); end
      default:   begin cx = PW'(ox);             cy = PW'(oy);             end
    endcase
  end

  always_comb begin
    cmd.rd    = (state == S_ISSUE);
    cmd.wr    = (state == S_MARK) || (in_fire && action == ACT_LOAD && in_grid);
    cmd.wdata = (state == S_MARK) ? 1'b0 : cell_free;
    if (state == S_IDLE) begin
      mx_addr = PW'(cell_x);
      my_addr = PW'(cell_y);
    end else if (state == S_MARK) begin
      mx_addr = PW'(ox) + PW'(mx);
      my_addr = PW'(oy) + PW'(my);
    end else begin
      mx_addr = cx;
      my_addr = cy;
    end
  end

  grrg_map #(
    .GRID_WIDTH (GRID_WIDTH),
    .GRID_HEIGHT(GRID_HEIGHT),
    .PW         (PW)
  ) u_map (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .x       (mx_addr),
    .y       (my_addr),
    .busy    (map_busy),
    .open_bit(open_bit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_ORIGIN;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire && action == ACT_BUILD) begin
            ox    <= CB'(cell_x);
            oy    <= CB'(cell_y);
            phase <= PH_ORIGIN;
            if (in_grid) begin
              state <= S_ISSUE;
            end else begin
              rw    <= '0;
              rh    <= '0;
              rok   <= 1'b0;
              state <= S_OUT;
            end
          end
        end
        S_ISSUE: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          state <= S_ISSUE;
          case (phase)
            PH_ORIGIN: begin
              if (!open_bit) begin
                rw    <= '0;
                rh    <= '0;
                rok   <= 1'b0;
                state <= S_OUT;
              end else begin
                side  <= CB'(1);
                k     <= '0;
                phase <= PH_SQ_COL;
              end
            end
            PH_SQ_COL, PH_SQ_ROW: begin
              if (!open_bit) begin
                wide  <= side;
                k     <= '0;
                phase <= PH_WIDE;
              end else if (k == side) begin
                k <= '0;
                if (phase == PH_SQ_COL) begin
                  phase <= PH_SQ_ROW;
                end else begin
                  side  <= side + 1'b1;
                  phase <= PH_SQ_COL;
                end
              end else begin
                k <= k + 1'b1;
              end
            end
            PH_WIDE: begin
              if (!open_bit) begin
                tall  <= side;
                k     <= '0;
                phase <= PH_TALL;
              end else if (k == side_m1) begin
                wide <= wide + 1'b1;
                k    <= '0;
              end else begin
                k <= k + 1'b1;
              end
            end
            PH_TALL: begin
              if (!open_bit) begin
                if (tall > wide) begin
                  rw <= side;
                  rh <= tall;
                end else begin
                  rw <= wide;
                  rh <= side;
                end
                rok   <= 1'b1;
                mx    <= '0;
                my    <= '0;
                state <= S_MARK;
              end else if (k == side_m1) begin
                tall <= tall + 1'b1;
                k    <= '0;
              end else begin
                k <= k + 1'b1;
              end
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end
        S_MARK: begin
          if (my == rh - 1'b1) begin
            my <= '0;
            if (mx == rw - 1'b1) begin
              state <= S_OUT;
            end else begin
              mx <= mx + 1'b1;
            end
          end else begin
            my <= my + 1'b1;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || out_ready)) begin
      room_width  <= SIZE_W'(rw);
      room_height <= SIZE_W'(rh);
      room_ok     <= rok;
    end
  end

endmodule

FILE: rtl/core/grrg_map.sv
// Free-cell bitmap: one bit per cell, row-major, with a clearing pass after reset.
// Depends on grrg_pkg. Cells outside the grid read as blocked.
module grrg_map
  import grrg_pkg::*;
#(
  parameter int GRID_WIDTH  = 64,
  parameter int GRID_HEIGHT = 64,
  parameter int PW          = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  map_cmd_t      cmd,
  input  logic [PW-1:0] x,
  input  logic [PW-1:0] y,
  output logic          busy,
  output logic          open_bit
);

  localparam int N  = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW = $clog2(N);

  logic          mem [N];
  logic [AW:0]   clr_cnt;
  logic [AW-1:0] addr;
  logic          in_grid;
  logic          rd_bit;
  logic          rd_ok;

  assign busy    = (clr_cnt != (AW+1)'(N));
  assign in_grid = (x < PW'(GRID_WIDTH)) && (y < PW'(GRID_HEIGHT));
  assign addr    = in_grid ? (AW'(y) * AW'(GRID_WIDTH) + AW'(x)) : '0;
  assign open_bit = rd_bit & rd_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (busy) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_cnt[AW-1:0]] <= 1'b0;
    end else if (cmd.wr && in_grid) begin
      mem[addr] <= cmd.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_bit <= mem[addr];
      rd_ok  <= in_grid;
    end
  end

endmodule

FILE: rtl/core/grrg_checker.sv
// Port-level checks for the grid rectangle room grower, bound to the top level.
// Depends on grrg_pkg and grid_rectangle_room_grower_top.
module grrg_checker
  import grrg_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [SIZE_W-1:0] room_width,
  input logic [SIZE_W-1:0] room_height,
  input logic              room_ok
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(room_width) &&
      $stable(room_height) && $stable(room_ok))
    else $error("output beat changed while stalled");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !room_ok |-> room_width == '0 && room_height == '0)
    else $error("failed build reports nonzero size");

  a_ok_size: assert property (@(posedge clk) disable iff (rst)
    out_valid && room_ok |-> room_width != '0 && room_height != '0)
    else $error("built room has zero size");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !in_ready)
    else $error("channels active right after reset");

endmodule

bind grid_rectangle_room_grower_top grrg_checker u_grrg_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .room_width (room_width),
  .room_height(room_height),
  .room_ok    (room_ok)
);

FILE: tb/sv/tb.sv
// Self-checking testbench for grid_rectangle_room_grower_top.
// Keeps its own copy of the free-cell map and predicts every room; needs grrg_pkg and the RTL.
module tb;
  import grrg_pkg::*;

  localparam int GRID_W      = 64;
  localparam int GRID_H      = 64;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic              ok;
  } room_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic                  action;
  logic [COORD_IN_W-1:0] cell_x;
  logic [COORD_IN_W-1:0] cell_y;
  logic                  cell_free;
  logic                  out_valid;
  logic                  out_ready;
  logic [SIZE_W-1:0]     room_width;
  logic [SIZE_W-1:0]     room_height;
  logic                  room_ok;

  bit    free_cells [GRID_H][GRID_W];
  room_t pending_rooms [$];
  room_t head_room;
  int    error_count = 0;
  int    items_sent  = 0;
  int    cycle_count = 0;
  bit    quiet_tail  = 0;

  grid_rectangle_room_grower_top #(
    .GRID_WIDTH (GRID_W),
    .GRID_HEIGHT(GRID_H)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .cell_x     (cell_x),
    .cell_y     (cell_y),
    .cell_free  (cell_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .room_width (room_width),
    .room_height(room_height),
    .room_ok    (room_ok)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic bit cell_open(int x, int y);
    if (x < 0 || y < 0 || x >= GRID_W || y >= GRID_H) return 1'b0;
    return free_cells[y][x];
  endfunction

  function automatic bit column_open(int x, int y0, int y1);
    for (int y = y0; y <= y1; y++)
      if (!cell_open(x, y)) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit row_open(int y, int x0, int x1);
    for (int x = x0; x <= x1; x++)
      if (!cell_open(x, y)) return 1'b0;
    return 1'b1;
  endfunction

  // Grows the room in the local map, marks it taken, returns its size.
  function automatic room_t grow_room(int ox, int oy);
    room_t r;
    int    side, wide_w, tall_h, w, h;
    r = '0;
    if (!cell_open(ox, oy)) return r;
    side = 1;
    while (column_open(ox + side, oy, oy + side) && row_open(oy + side, ox, ox + side))
      side++;
    wide_w = side;
    while (column_open(ox + wide_w, oy, oy + side - 1)) wide_w++;
    tall_h = side;
    while (row_open(oy + tall_h, ox, ox + side - 1)) tall_h++;
    if (tall_h * side > side * wide_w) begin
      w = side;
      h = tall_h;
    end else begin
      w = wide_w;
      h = side;
    end
    for (int x = ox; x < ox + w; x++)
      for (int y = oy; y < oy + h; y++)
        if (x < GRID_W && y < GRID_H) free_cells[y][x] = 1'b0;
    r.width  = w[SIZE_W-1:0];
    r.height = h[SIZE_W-1:0];
    r.ok     = 1'b1;
    return r;
  endfunction

  task automatic send_item(logic act, int x, int y, logic fr);
    in_valid  <= 1'b1;
    action    <= act;
    cell_x    <= x[COORD_IN_W-1:0];
    cell_y    <= y[COORD_IN_W-1:0];
    cell_free <= fr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (act == ACT_BUILD)
      pending_rooms.push_back(grow_room(x, y));
    else if (x < GRID_W && y < GRID_H)
      free_cells[y][x] = fr;
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic wait_for_rooms();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_rooms.size() != 0) @(posedge clk);
  endtask

  task automatic load_block(int x0, int y0, int w, int h, int blocked_pct);
    for (int y = y0; y < y0 + h && y < GRID_H; y++)
      for (int x = x0; x < x0 + w && x < GRID_W; x++)
        send_item(ACT_LOAD, x, y, $urandom_range(0, 99) >= blocked_pct);
  endtask

  // blocked or cleared origins fail and leave the map alone
  task automatic test_blocked_origin();
    send_item(ACT_BUILD, 0, 0, 1'b1);
    send_item(ACT_BUILD, GRID_W - 1, GRID_H - 1, 1'b0);
    send_item(ACT_BUILD, GRID_W - 1, 0, 1'b1);
    send_item(ACT_LOAD, 7, 7, 1'b1);
    send_item(ACT_LOAD, 7, 7, 1'b0);
    send_item(ACT_BUILD, 7, 7, 1'b1);
  endtask

  task automatic test_single_cell();
    send_item(ACT_LOAD, GRID_W - 1, GRID_H - 1, 1'b1);
    send_item(ACT_BUILD, GRID_W - 1, GRID_H - 1, 1'b0);
    send_item(ACT_BUILD, GRID_W - 1, GRID_H - 1, 1'b1);
  endtask

  // equal areas keep the widened room; a taller room wins on area
  task automatic test_tie_and_tall();
    load_block(10, 10, 3, 2, 0);
    load_block(10, 12, 2, 1, 0);
    send_item(ACT_BUILD, 10, 10, 1'b0);
    send_item(ACT_BUILD, 10, 12, 1'b1);
    load_block(20, 20, 2, 4, 0);
    send_item(ACT_BUILD, 20, 20, 1'b1);
  endtask

  task automatic test_grid_edges();
    load_block(GRID_W - 4, GRID_H - 4, 4, 4, 0);
    send_item(ACT_BUILD, GRID_W - 4, GRID_H - 4, 1'b0);
    load_block(0, 0, GRID_W, 1, 0);
    send_item(ACT_BUILD, 0, 0, 1'b1);
    load_block(0, 0, 1, GRID_H, 0);
    send_item(ACT_BUILD, 0, 0, 1'b0);
  endtask

  task automatic test_random_rooms(int count);
    int stop_at, w, h, x0, y0, ox, oy, episode;
    stop_at = items_sent + count;
    episode = 0;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 11) == 0) begin
        w = $urandom_range(8, 24);
        h = $urandom_range(1, 3);
      end else begin
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 8);
      end
      x0 = $urandom_range(0, GRID_W - 1);
      y0 = $urandom_range(0, GRID_H - 1);
      load_block(x0, y0, w, h, $urandom_range(0, 15));
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 2) != 0) begin
          ox = x0;
          oy = y0;
        end else begin
          ox = x0 + $urandom_range(0, w - 1);
          oy = y0 + $urandom_range(0, h - 1);
        end
        if (ox > GRID_W - 1) ox = GRID_W - 1;
        if (oy > GRID_H - 1) oy = GRID_H - 1;
        send_item(ACT_BUILD, ox, oy, $urandom_range(0, 1));
      end
      if ($urandom_range(0, 4) == 0)
        send_item(ACT_BUILD, $urandom_range(0, GRID_W - 1), $urandom_range(0, GRID_H - 1),
                  $urandom_range(0, 1));
      if ($urandom_range(0, 6) == 0)
        send_item(ACT_LOAD, $urandom_range(0, GRID_W - 1), $urandom_range(0, GRID_H - 1),
                  $urandom_range(0, 1));
      episode++;
      if (episode % 10 == 0) wait_for_rooms();
    end
  endtask

  task automatic test_back_to_back();
    quiet_tail = 1;
    test_random_rooms(40);
  endtask

  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (pending_rooms.size() == 0) begin
        $error("result beat with no build pending");
        error_count++;
      end else begin
        head_room = pending_rooms.pop_front();
        if (room_width !== head_room.width) begin
          $error("room_width: expected %0d, got %0d", head_room.width, room_width);
          error_count++;
        end
        if (room_height !== head_room.height) begin
          $error("room_height: expected %0d, got %0d", head_room.height, room_height);
          error_count++;
        end
        if (room_ok !== head_room.ok) begin
          $error("room_ok: expected %0d, got %0d", head_room.ok, room_ok);
          error_count++;
        end
      end
    end
  end

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    action    <= ACT_LOAD;
    cell_x    <= '0;
    cell_y    <= '0;
    cell_free <= 1'b0;
    foreach (free_cells[y, x]) free_cells[y][x] = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_blocked_origin();
    test_single_cell();
    test_tie_and_tall();
    test_grid_edges();
    test_random_rooms(400);
    test_back_to_back();
    wait_for_rooms();
    if (pending_rooms.size() != 0) begin
      $error("builds left without a result: %0d", pending_rooms.size());
      error_count++;
    end
    repeat (300) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/grrg_pkg.sv
rtl/core/grrg_map.sv
rtl/core/grid_rectangle_room_grower_top.sv
rtl/core/grrg_checker.sv
tb/sv/tb.sv
